/* rtl/bcss_pkg.sv */
package bcss_pkg;

  // Number of segments along each curve; SEGMENTS+1 samples are produced.
  localparam int SEGMENTS = 20;
  localparam int SEG_CNT  = SEGMENTS + 1;
  localparam int TAB_W    = (SEG_CNT > 1) ? $clog2(SEG_CNT) : 1;

  // Field widths.
  localparam int COORD_W = 16;
  localparam int SW_W    = 15;
  localparam int IDX_W   = 6;
  localparam int WGT_W   = 17;

  // Result queue depth and the width of a counter that can hold it.
  localparam int OFIFO_DEPTH = 8;
  localparam int OPTR_W      = $clog2(OFIFO_DEPTH);
  localparam int OCNT_W      = OPTR_W + 1;

  // Curve queue between the front and the back.
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = CQ_PTR_W + 1;

  localparam longint unsigned ONE_Q16 = 64'd65536;

  // The sample parameter t advances by 65536/SEGMENTS per sample; the quotient and
  // remainder of that step and of the rounding offset are fixed at elaboration.
  localparam longint unsigned SEG_DIV  = 64'(SEGMENTS);
  localparam longint unsigned T_STEP_Q = ONE_Q16 / SEG_DIV;
  localparam longint unsigned T_STEP_R = ONE_Q16 % SEG_DIV;
  localparam longint unsigned T_INIT_Q = 64'(SEGMENTS / 2) / SEG_DIV;
  localparam longint unsigned T_INIT_R = 64'(SEGMENTS / 2) % SEG_DIV;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } pt_t;

  // Raw input transaction as it arrives on the ports.
  typedef struct packed {
    pt_t  start_p;
    pt_t  end_p;
    pt_t  ctrl1_p;
    pt_t  ctrl2_p;
    logic is_cubic;
  } item_t;

  // Classified curve: four points in weight order, unused point is zero.
  typedef struct packed {
    pt_t [3:0] pts;
    logic      cubic;
  } curve_t;

  // One result transaction.
  typedef struct packed {
    logic signed [COORD_W-1:0] sample_x;
    logic signed [COORD_W-1:0] sample_y;
    logic signed [COORD_W-1:0] baseline_y;
    logic [IDX_W-1:0]          sample_index;
    logic                      last_sample;
  } res_t;

  // Status passed from the result queue to the top level.
  typedef struct packed {
    logic empty;
    logic full;
  } ofifo_stat_t;

  typedef logic [SEG_CNT-1:0][3:0][WGT_W-1:0] wtab_t;

  // Bernstein weights in Q1.16 for every sample, rounded half up.
  // t is kept as a running quotient and remainder, so no division is needed per sample.
  function automatic wtab_t build_wtab(input logic cubic);
    wtab_t           tab;
    longint unsigned t_q;
    longint unsigned t_r;
    longint unsigned t;
    longint unsigned u;
    tab = '0;
    t_q = T_INIT_Q;
    t_r = T_INIT_R;
    for (int i = 0; i < SEG_CNT; i++) begin
      t = (t_q > ONE_Q16) ? ONE_Q16 : t_q;
      u = ONE_Q16 - t;
      if (cubic) begin
        tab[i][0] = WGT_W'((u * u * u + 64'h8000_0000) >> 32);
        tab[i][1] = WGT_W'((64'd3 * u * u * t + 64'h8000_0000) >> 32);
        tab[i][2] = WGT_W'((64'd3 * u * t * t + 64'h8000_0000) >> 32);
        tab[i][3] = WGT_W'((t * t * t + 64'h8000_0000) >> 32);
      end else begin
        tab[i][0] = WGT_W'((u * u + 64'h8000) >> 16);
        tab[i][1] = WGT_W'((64'd2 * u * t + 64'h8000) >> 16);
        tab[i][2] = WGT_W'((t * t + 64'h8000) >> 16);
        tab[i][3] = '0;
      end
      // Step to the next sample; a full remainder carries into the quotient.
      t_q = t_q + T_STEP_Q;
      t_r = t_r + T_STEP_R;
      if (t_r >= SEG_DIV) begin
        t_q = t_q + 64'd1;
        t_r = t_r - SEG_DIV;
      end
    end
    return tab;
  endfunction

  localparam wtab_t W_QUAD  = build_wtab(1'b0);
  localparam wtab_t W_CUBIC = build_wtab(1'b1);

endpackage

/* rtl/bcss_front.sv */
module bcss_front
  import bcss_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  item_t  item,
  output logic   full,
  output logic   crv_valid,
  output curve_t crv,
  input  logic   crv_take
);

  curve_t                cq_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [CQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                  acc;
  curve_t                cls;

  assign full      = (cnt_r == CQ_CNT_W'(CQ_DEPTH));
  assign acc       = push && !full;
  assign crv_valid = (cnt_r != '0);
  assign crv       = cq_r[rd_ptr_r];

  // Put the points in weight order; a quadratic curve drops the second control point.
  always_comb begin
    cls.cubic  = item.is_cubic;
    cls.pts[0] = item.start_p;
    cls.pts[1] = item.ctrl1_p;
    if (item.is_cubic) begin
      cls.pts[2] = item.ctrl2_p;
      cls.pts[3] = item.end_p;
    end else begin
      cls.pts[2] = item.end_p;
      cls.pts[3] = '0;
    end
  end

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = acc ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = crv_take ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CQ_CNT_W'(acc) - CQ_CNT_W'(crv_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Curve storage.
  always_ff @(posedge clk) begin
    if (acc) begin
      cq_r[wr_ptr_r] <= cls;
    end
  end

endmodule

/* rtl/bcss_back.sv */
module bcss_back
  import bcss_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            crv_valid,
  input  curve_t          crv,
  output logic            crv_take,
  input  logic [SW_W-1:0] stroke_width,
  input  logic            out_pop,
  output logic            res_wr,
  output res_t            res
);

  localparam int PROD_W = WGT_W + 1 + COORD_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int RND_W  = SUM_W - 16;

  function automatic logic signed [COORD_W-1:0] sat_rnd(input logic signed [RND_W-1:0] v);
    if (v > RND_W'(32767)) begin
      return 16'sh7FFF;
    end else if (v < -RND_W'(32768)) begin
      return 16'sh8000;
    end
    return v[COORD_W-1:0];
  endfunction

  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [OCNT_W-1:0] resv_r, resv_nxt;
  logic              issue;
  logic              is_last;

  logic                     va_r;
  logic [3:0][WGT_W-1:0]    wa_r;
  pt_t  [3:0]               pa_r;
  logic [IDX_W-1:0]         idx_a_r;
  logic                     last_a_r;

  logic                     vb_r;
  logic signed [PROD_W-1:0] px_r [4];
  logic signed [PROD_W-1:0] py_r [4];
  logic signed [PROD_W-1:0] px_nxt [4];
  logic signed [PROD_W-1:0] py_nxt [4];
  logic [IDX_W-1:0]         idx_b_r;
  logic                     last_b_r;

  logic                      vc_r;
  logic signed [SUM_W-1:0]   sum_x, sum_y;
  logic signed [RND_W-1:0]   rnd_x, rnd_y;
  logic signed [COORD_W-1:0] sx_r, sy_r;
  logic [IDX_W-1:0]          idx_c_r;
  logic                      last_c_r;

  logic                      vd_r;
  logic signed [COORD_W:0]   by_wide;
  res_t                      res_r;

  // Sample sequencer: issue while the result queue still has a free reserved slot.
  assign is_last  = (idx_r == IDX_W'(SEGMENTS));
  assign issue    = crv_valid && (resv_r < OCNT_W'(OFIFO_DEPTH));
  assign crv_take = issue && is_last;

  always_comb begin
    idx_nxt = idx_r;
    if (issue) begin
      idx_nxt = is_last ? '0 : idx_r + 1'b1;
    end
    resv_nxt = resv_r + OCNT_W'(issue) - OCNT_W'(out_pop);
  end

  // Valid bits of the pipeline and the sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      resv_r <= '0;
      va_r   <= 1'b0;
      vb_r   <= 1'b0;
      vc_r   <= 1'b0;
      vd_r   <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      resv_r <= resv_nxt;
      va_r   <= issue;
      vb_r   <= va_r;
      vc_r   <= vb_r;
      vd_r   <= vc_r;
    end
  end

  // Stage A: weight table lookup and point capture.
  always_ff @(posedge clk) begin
    wa_r     <= crv.cubic ? W_CUBIC[idx_r[TAB_W-1:0]] : W_QUAD[idx_r[TAB_W-1:0]];
    pa_r     <= crv.pts;
    idx_a_r  <= idx_r;
    last_a_r <= is_last;
  end

  // Stage B: eight weight-by-coordinate products.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      px_nxt[k] = $signed({1'b0, wa_r[k]}) * pa_r[k].x;
      py_nxt[k] = $signed({1'b0, wa_r[k]}) * pa_r[k].y;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      px_r[k] <= px_nxt[k];
      py_r[k] <= py_nxt[k];
    end
    idx_b_r  <= idx_a_r;
    last_b_r <= last_a_r;
  end

  // Stage C: sum, round half up to Q12.4 and saturate.
  always_comb begin
    sum_x = SUM_W'(px_r[0]) + SUM_W'(px_r[1]) + SUM_W'(px_r[2]) + SUM_W'(px_r[3])
            + SUM_W'(32768);
    sum_y = SUM_W'(py_r[0]) + SUM_W'(py_r[1]) + SUM_W'(py_r[2]) + SUM_W'(py_r[3])
            + SUM_W'(32768);
    rnd_x = sum_x[SUM_W-1:16];
    rnd_y = sum_y[SUM_W-1:16];
  end

  always_ff @(posedge clk) begin
    sx_r     <= sat_rnd(rnd_x);
    sy_r     <= sat_rnd(rnd_y);
    idx_c_r  <= idx_b_r;
    last_c_r <= last_b_r;
  end

  // Stage D: baseline offset with saturation at the lower bound.
  assign by_wide = (COORD_W + 1)'(sy_r) - $signed({2'b00, stroke_width});

  always_ff @(posedge clk) begin
    res_r.sample_x     <= sx_r;
    res_r.sample_y     <= sy_r;
    res_r.baseline_y   <= (by_wide < -(COORD_W + 1)'(32768)) ? 16'sh8000
                                                             : by_wide[COORD_W-1:0];
    res_r.sample_index <= idx_c_r;
    res_r.last_sample  <= last_c_r;
  end

  assign res_wr = vd_r;
  assign res    = res_r;

endmodule

/* rtl/bcss_ofifo.sv */
module bcss_ofifo
  import bcss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr,
  input  res_t        wr_data,
  input  logic        rd,
  output res_t        rd_data,
  output ofifo_stat_t stat
);

  res_t              mem_r [OFIFO_DEPTH];
  logic [OPTR_W-1:0] wr_ptr_r;
  logic [OPTR_W-1:0] rd_ptr_r;
  logic [OCNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == OCNT_W'(OFIFO_DEPTH));
  assign rd_data    = mem_r[rd_ptr_r];

  // Fill count follows writes and reads.
  assign cnt_nxt = cnt_r + OCNT_W'(wr) - OCNT_W'(rd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/bezier_curve_strip_sampler.sv */
// Channel  Dir  Handshake    Ports
// input    in   push / full  in_start_*, in_end_*, in_ctrl1_*, in_ctrl2_*, in_is_cubic
// result   out  pop / empty  out_sample_x/y, out_baseline_y, out_sample_index, out_last_sample
// config   in   cfg_we       cfg_data (stroke width, unsigned Q11.4)
//
// Each curve yields SEGMENTS+1 samples, one per cycle from the sample sequencer while a
// curve is queued and the result queue has a free reserved slot; each sample passes the
// curve queue, pipeline stages A to D and the result queue on its way to the result ports.
// A two-entry curve queue lets a new curve be accepted while the previous one is sampled.
// Samples are issued only against free slots of the eight-entry result queue, so a stalled
// pop holds the sequencer without losing anything in the multiply pipeline.
// Synchronous active-low reset empties both queues; the stroke width resets to 16.
module bezier_curve_strip_sampler
  import bcss_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic signed [COORD_W-1:0] in_start_x,
  input  logic signed [COORD_W-1:0] in_start_y,
  input  logic signed [COORD_W-1:0] in_end_x,
  input  logic signed [COORD_W-1:0] in_end_y,
  input  logic signed [COORD_W-1:0] in_ctrl1_x,
  input  logic signed [COORD_W-1:0] in_ctrl1_y,
  input  logic signed [COORD_W-1:0] in_ctrl2_x,
  input  logic signed [COORD_W-1:0] in_ctrl2_y,
  input  logic                      in_is_cubic,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [COORD_W-1:0] out_sample_x,
  output logic signed [COORD_W-1:0] out_sample_y,
  output logic signed [COORD_W-1:0] out_baseline_y,
  output logic [IDX_W-1:0]          out_sample_index,
  output logic                      out_last_sample,
  input  logic                      cfg_we,
  input  logic [SW_W-1:0]           cfg_data
);

  logic [SW_W-1:0] stroke_width_r;
  item_t           item;
  logic            crv_valid;
  curve_t          crv;
  logic            crv_take;
  logic            out_pop;
  logic            res_wr;
  res_t            res;
  res_t            head;
  ofifo_stat_t     ostat;

  // Stroke width register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stroke_width_r <= SW_W'(16);
    end else if (cfg_we) begin
      stroke_width_r <= cfg_data;
    end
  end

  // Gather the input transaction.
  always_comb begin
    item.start_p.x = in_start_x;
    item.start_p.y = in_start_y;
    item.end_p.x   = in_end_x;
    item.end_p.y   = in_end_y;
    item.ctrl1_p.x = in_ctrl1_x;
    item.ctrl1_p.y = in_ctrl1_y;
    item.ctrl2_p.x = in_ctrl2_x;
    item.ctrl2_p.y = in_ctrl2_y;
    item.is_cubic  = in_is_cubic;
  end

  bcss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .item      (item),
    .full      (full),
    .crv_valid (crv_valid),
    .crv       (crv),
    .crv_take  (crv_take)
  );

  bcss_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .crv_valid    (crv_valid),
    .crv          (crv),
    .crv_take     (crv_take),
    .stroke_width (stroke_width_r),
    .out_pop      (out_pop),
    .res_wr       (res_wr),
    .res          (res)
  );

  bcss_ofifo u_ofifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (res_wr),
    .wr_data (res),
    .rd      (out_pop),
    .rd_data (head),
    .stat    (ostat)
  );

  // Result ports.
  assign empty            = ostat.empty;
  assign out_pop          = pop && !ostat.empty;
  assign out_sample_x     = head.sample_x;
  assign out_sample_y     = head.sample_y;
  assign out_baseline_y   = head.baseline_y;
  assign out_sample_index = head.sample_index;
  assign out_last_sample  = head.last_sample;

  // The credit scheme must never let the result queue overflow.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_wr |-> (!ostat.full || out_pop))
    else $error("result queue written while full");

  // A curve is released only when the queue holds one.
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    crv_take |-> crv_valid)
    else $error("curve released from an empty queue");

  // The final-sample flag travels with the final index.
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    res_wr |-> (res.last_sample == (res.sample_index == IDX_W'(SEGMENTS))))
    else $error("last-sample flag does not match the sample index");

endmodule
